// File: rtl/sppv_pkg.sv
package sppv_pkg;

	localparam int DEF_MAX_SIDE = 1024;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_IMAGE_SIZE = 2'd0;
	localparam logic [1:0] REG_BASE_RED   = 2'd1;
	localparam logic [1:0] REG_BASE_GREEN = 2'd2;
	localparam logic [1:0] REG_BASE_BLUE  = 2'd3;

	localparam logic [10:0] RST_IMAGE_SIZE = 11'd64;
	localparam logic [7:0]  RST_BASE       = 8'd255;

	// Unit light direction in Q16.
	localparam logic signed [17:0] LIGHT_X = -18'sd23499;
	localparam logic signed [17:0] LIGHT_Y = -18'sd39165;
	localparam logic signed [17:0] LIGHT_Z = 18'sd46998;

	localparam logic [17:0] AMBIENT_Q16 = 18'd14418;
	localparam logic [15:0] DIFFUSE_Q16 = 16'd47186;

	localparam logic [7:0] CHECK_DARK  = 8'd45;
	localparam logic [7:0] CHECK_LIGHT = 8'd58;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	// Square root unit: radicand at most 2^32, root at most 2^16.
	localparam int SQ_IN_W  = 33;
	localparam int SQ_ACC_W = 34;
	localparam int SQ_RES_W = 17;
	localparam int SQ_STEPS = 17;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

endpackage

// File: rtl/sppv_div.sv
module sppv_div #(
	parameter int NUMW = 32,
	parameter int DW = 15,
	parameter int SBW = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [NUMW-1:0] num_a,
	input  logic [NUMW-1:0] num_b,
	input  logic [DW-1:0]   den,
	input  logic [SBW-1:0]  sb_in,
	output logic            out_valid,
	output logic [NUMW-1:0] quo_a,
	output logic [NUMW-1:0] quo_b,
	output logic [SBW-1:0]  sb_out
);

	// Two restoring dividers sharing one divisor; one quotient bit per stage.
	logic            v_s  [0:NUMW];
	logic [DW-1:0]   ra_s [0:NUMW];
	logic [DW-1:0]   rb_s [0:NUMW];
	logic [NUMW-1:0] na_s [0:NUMW];
	logic [NUMW-1:0] nb_s [0:NUMW];
	logic [DW-1:0]   d_s  [0:NUMW];
	logic [SBW-1:0]  sb_s [0:NUMW];

	assign v_s[0]  = in_valid;
	assign ra_s[0] = '0;
	assign rb_s[0] = '0;
	assign na_s[0] = num_a;
	assign nb_s[0] = num_b;
	assign d_s[0]  = den;
	assign sb_s[0] = sb_in;

	for (genvar k = 0; k < NUMW; k++) begin : g_step
		logic [DW:0]   ta, tb;
		logic          qa, qb;
		logic [DW-1:0] ra_n, rb_n;

		always_comb begin
			ta = {ra_s[k], na_s[k][NUMW-1]};
			tb = {rb_s[k], nb_s[k][NUMW-1]};
			qa = ta >= {1'b0, d_s[k]};
			qb = tb >= {1'b0, d_s[k]};
			ra_n = qa ? DW'(ta - {1'b0, d_s[k]}) : ta[DW-1:0];
			rb_n = qb ? DW'(tb - {1'b0, d_s[k]}) : tb[DW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[k+1] <= ra_n;
				rb_s[k+1] <= rb_n;
				na_s[k+1] <= {na_s[k][NUMW-2:0], qa};
				nb_s[k+1] <= {nb_s[k][NUMW-2:0], qb};
				d_s[k+1]  <= d_s[k];
				sb_s[k+1] <= sb_s[k];
			end
		end
	end

	assign out_valid = v_s[NUMW];
	assign quo_a     = na_s[NUMW];
	assign quo_b     = nb_s[NUMW];
	assign sb_out    = sb_s[NUMW];

endmodule

// File: rtl/sppv_isqrt.sv
module sppv_isqrt import sppv_pkg::*; #(
	parameter int SBW = 38
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [SQ_IN_W-1:0]  rad,
	input  logic [SBW-1:0]      sb_in,
	output logic                out_valid,
	output logic [SQ_RES_W-1:0] root,
	output logic [SBW-1:0]      sb_out
);

	// Digit-by-digit square root, one result bit per stage.
	logic                v_s  [0:SQ_STEPS];
	logic [SQ_IN_W-1:0]  x_s  [0:SQ_STEPS];
	logic [SQ_ACC_W-1:0] r_s  [0:SQ_STEPS];
	logic [SBW-1:0]      sb_s [0:SQ_STEPS];

	assign v_s[0]  = in_valid;
	assign x_s[0]  = rad;
	assign r_s[0]  = '0;
	assign sb_s[0] = sb_in;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_ACC_W-1:0] BIT = SQ_ACC_W'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [SQ_ACC_W-1:0] sum;
		logic                ge;
		logic [SQ_IN_W-1:0]  x_n;
		logic [SQ_ACC_W-1:0] r_n;

		always_comb begin
			sum = r_s[k] + BIT;
			ge  = {1'b0, x_s[k]} >= sum;
			x_n = ge ? SQ_IN_W'({1'b0, x_s[k]} - sum) : x_s[k];
			r_n = ge ? ((r_s[k] >> 1) + BIT) : (r_s[k] >> 1);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]  <= x_n;
				r_s[k+1]  <= r_n;
				sb_s[k+1] <= sb_s[k];
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS];
	assign root      = r_s[SQ_STEPS][SQ_RES_W-1:0];
	assign sb_out    = sb_s[SQ_STEPS];

endmodule

// File: rtl/sphere_preview_pixel_shader_top.sv
// Path from an accepted pixel to its color: the stage 1 register, the bit-per-stage coordinate
// dividers, stages 2 and 3, the 17-stage square root and stages 4 to 7.
// Throughput: one pixel per cycle; the whole pipeline advances together and holds
// while the output transaction waits.
// Reset clears all valid bits and loads image_size 64 and base color 255, 255, 255.
module sphere_preview_pixel_shader_top import sppv_pkg::*; #(
	parameter int MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  logic [9:0]  pos_x,
	input  logic [9:0]  pos_y,
	output logic        rgba_valid,
	input  logic        rgba_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha
);

	localparam int AW   = $clog2(MAX_SIDE > 2048 ? MAX_SIDE : 2048);
	localparam int SW   = AW + 2;
	localparam int SDW  = $clog2(MAX_SIDE + 1);
	localparam int NUMW = AW + 21;
	localparam int DW   = $clog2(19 * MAX_SIDE + 1);
	localparam int ISB  = 38;

	// Configuration registers.
	logic [10:0] size_q;
	logic [7:0]  base_r_q, base_g_q, base_b_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= RST_IMAGE_SIZE;
			base_r_q <= RST_BASE;
			base_g_q <= RST_BASE;
			base_b_q <= RST_BASE;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_IMAGE_SIZE: size_q   <= pwdata[10:0];
				REG_BASE_RED:   base_r_q <= pwdata[7:0];
				REG_BASE_GREEN: base_g_q <= pwdata[7:0];
				REG_BASE_BLUE:  base_b_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_IMAGE_SIZE: prdata = {21'd0, size_q};
			REG_BASE_RED:   prdata = {24'd0, base_r_q};
			REG_BASE_GREEN: prdata = {24'd0, base_g_q};
			REG_BASE_BLUE:  prdata = {24'd0, base_b_q};
			default:        prdata = '0;
		endcase
	end

	// One enable moves every stage; the output register frees when taken.
	logic en;
	logic v_s7;

	assign en        = !v_s7 || rgba_ready;
	assign pix_ready = en;

	// Stage 1: signed offsets from the center, scaled numerators and divisor.
	logic [SDW-1:0]  side;
	logic [SW-1:0]   ax, ay;
	logic [AW-1:0]   mag_x, mag_y;
	logic [AW+4:0]   m25_x, m25_y;
	logic [DW-1:0]   den;

	always_comb begin
		if ({21'd0, size_q} > 32'(MAX_SIDE)) begin
			side = SDW'(MAX_SIDE);
		end else if (size_q == 11'd0) begin
			side = SDW'(1);
		end else begin
			side = SDW'(size_q);
		end
		ax    = SW'({pos_x, 1'b0}) - SW'(side) + SW'(1);
		ay    = SW'({pos_y, 1'b0}) - SW'(side) + SW'(1);
		mag_x = ax[SW-1] ? AW'(-ax) : AW'(ax);
		mag_y = ay[SW-1] ? AW'(-ay) : AW'(ay);
		m25_x = (AW+5)'({mag_x, 4'd0}) + (AW+5)'({mag_x, 3'd0}) + (AW+5)'(mag_x);
		m25_y = (AW+5)'({mag_y, 4'd0}) + (AW+5)'({mag_y, 3'd0}) + (AW+5)'(mag_y);
		den   = DW'({side, 4'd0}) + DW'({side, 1'b0}) + DW'(side);
	end

	logic            v_s1;
	logic [NUMW-1:0] numx_s1, numy_s1;
	logic [DW-1:0]   den_s1;
	logic [2:0]      sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s1 <= {m25_x, 16'd0};
			numy_s1 <= {m25_y, 16'd0};
			den_s1  <= den;
			sb_s1   <= {pos_x[3] ^ pos_y[3], ax[SW-1], ay[SW-1]};
		end
	end

	logic            v_dv;
	logic [NUMW-1:0] qx, qy;
	logic [2:0]      sb_dv;

	sppv_div #(
		.NUMW (NUMW),
		.DW   (DW),
		.SBW  (3)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.num_a     (numx_s1),
		.num_b     (numy_s1),
		.den       (den_s1),
		.sb_in     (sb_s1),
		.out_valid (v_dv),
		.quo_a     (qx),
		.quo_b     (qy),
		.sb_out    (sb_dv)
	);

	// Stage 2: squares of the clipped magnitudes.
	logic        v_s2, over_s2, par_s2, sx_s2, sy_s2;
	logic [16:0] mx_s2, my_s2;
	logic [33:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			over_s2 <= (qx > NUMW'(ONE_Q16)) || (qy > NUMW'(ONE_Q16));
			mx_s2   <= qx[16:0];
			my_s2   <= qy[16:0];
			sqx_s2  <= 34'(qx[16:0]) * 34'(qy[16:0] & 17'd0 | qx[16:0]);
			sqy_s2  <= 34'(qy[16:0]) * 34'(qy[16:0]);
			par_s2  <= sb_dv[2];
			sx_s2   <= sb_dv[1];
			sy_s2   <= sb_dv[0];
		end
	end

	// Stage 3: disk test and the radicand 1 - d2.
	logic [34:0]        d2;
	logic               in_disk;
	logic               v_s3;
	logic [SQ_IN_W-1:0] rad_s3;
	logic [ISB-1:0]     sb_s3;

	assign d2      = 35'(sqx_s2) + 35'(sqy_s2);
	assign in_disk = !over_s2 && (d2 <= 35'h1_0000_0000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= in_disk ? SQ_IN_W'(35'h1_0000_0000 - d2) : '0;
			sb_s3  <= {par_s2, in_disk,
				sx_s2 ? 18'(-{1'b0, mx_s2}) : {1'b0, mx_s2},
				sy_s2 ? 18'(-{1'b0, my_s2}) : {1'b0, my_s2}};
		end
	end

	logic                v_sq;
	logic [SQ_RES_W-1:0] nz;
	logic [ISB-1:0]      sb_sq;

	sppv_isqrt #(
		.SBW (ISB)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.rad       (rad_s3),
		.sb_in     (sb_s3),
		.out_valid (v_sq),
		.root      (nz),
		.sb_out    (sb_sq)
	);

	// Stage 4: light products and the rim square.
	logic signed [17:0] nx, ny, nzs;
	logic [16:0]        t;

	assign nx  = sb_sq[35:18];
	assign ny  = sb_sq[17:0];
	assign nzs = {1'b0, nz};
	assign t   = ONE_Q16 - nz;

	logic               v_s4, par_s4, in_s4;
	logic signed [35:0] px_s4, py_s4, pz_s4;
	logic [33:0]        tt_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4  <= nx * LIGHT_X;
			py_s4  <= ny * LIGHT_Y;
			pz_s4  <= nzs * LIGHT_Z;
			tt_s4  <= 34'(t) * 34'(t);
			par_s4 <= sb_sq[37];
			in_s4  <= sb_sq[36];
		end
	end

	// Stage 5: dot product, clamped at zero.
	logic signed [36:0] dot;

	assign dot = 37'(px_s4) - 37'(py_s4) + 37'(pz_s4);

	logic        v_s5, par_s5, in_s5;
	logic [16:0] diff_s5;
	logic [15:0] rim_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s5 <= (dot > 37'sd0) ? dot[32:16] : '0;
			rim_s5  <= tt_s4[33:18];
			par_s5  <= par_s4;
			in_s5   <= in_s4;
		end
	end

	// Stage 6: lighting factor and the rim term scaled by 255.
	logic [32:0] dscale;

	assign dscale = 33'(diff_s5) * 33'(DIFFUSE_Q16);

	logic        v_s6, par_s6, in_s6;
	logic [17:0] fac_s6;
	logic [23:0] rim_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fac_s6 <= AMBIENT_Q16 + 18'(dscale[32:16]);
			rim_s6 <= {rim_s5, 8'd0} - 24'(rim_s5);
			par_s6 <= par_s5;
			in_s6  <= in_s5;
		end
	end

	// Stage 7: per-channel shading, saturation and the checkerboard.
	logic [26:0] ch_r, ch_g, ch_b;
	logic [7:0]  sat_r, sat_g, sat_b, grey;

	always_comb begin
		ch_r  = 27'(base_r_q) * 27'(fac_s6) + 27'(rim_s6);
		ch_g  = 27'(base_g_q) * 27'(fac_s6) + 27'(rim_s6);
		ch_b  = 27'(base_b_q) * 27'(fac_s6) + 27'(rim_s6);
		sat_r = (ch_r[26:16] > 11'd255) ? 8'd255 : ch_r[23:16];
		sat_g = (ch_g[26:16] > 11'd255) ? 8'd255 : ch_g[23:16];
		sat_b = (ch_b[26:16] > 11'd255) ? 8'd255 : ch_b[23:16];
		grey  = par_s6 ? CHECK_DARK : CHECK_LIGHT;
	end

	logic [7:0] r_s7, g_s7, b_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s7 <= in_s6 ? sat_r : grey;
			g_s7 <= in_s6 ? sat_g : grey;
			b_s7 <= in_s6 ? sat_b : grey;
		end
	end

	assign rgba_valid = v_s7;
	assign red        = r_s7;
	assign green      = g_s7;
	assign blue       = b_s7;
	assign alpha      = ALPHA_OPAQUE;

endmodule

// File: dv/tb_sphere_preview_pixel_shader_top.sv
`timescale 1ns / 100ps

module tb_sphere_preview_pixel_shader_top;
	import sppv_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	localparam int LIMIT_CYCLES = 1500000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        pix_valid = 1'b0;
	logic        pix_ready;
	logic [9:0]  pos_x = '0;
	logic [9:0]  pos_y = '0;
	logic        rgba_valid;
	logic        rgba_ready = 1'b0;
	logic [7:0]  red, green, blue, alpha;

	// Shadow copy of the shader's registers.
	logic [10:0] side_reg = RST_IMAGE_SIZE;
	logic [7:0]  base_r = RST_BASE, base_g = RST_BASE, base_b = RST_BASE;

	rgba_t color_queue[$];
	int    mismatches = 0;
	int    cycles = 0;
	int    hold_asks = 0;
	int    hold_taken = 0;
	int    hold_cycles = 0;
	int    pixels_sent = 0;
	int    pixels_done = 0;

	sphere_preview_pixel_shader_top i_dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("sphere_preview_pixel_shader_top regression: fail");
			$finish;
		end
	end

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else
				res >>= 1;
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint normal_coord(longint p, longint s);
		return ((2 * p - s + 1) * 25 * 65536) / (19 * s);
	endfunction

	function automatic logic [7:0] lit_channel(longint unsigned b, longint f, longint rim);
		longint unsigned v;
		v = (b * f + 255 * rim) >> 16;
		return v > 255 ? 8'd255 : v[7:0];
	endfunction

	function automatic rgba_t shade_pixel(logic [9:0] px, logic [9:0] py);
		longint s, nx, ny, nz, dotp, diff, t, rim, f;
		longint unsigned d2;
		rgba_t c;
		s = side_reg;
		if (s < 1) s = 1;
		if (s > DEF_MAX_SIDE) s = DEF_MAX_SIDE;
		nx = normal_coord(px, s);
		ny = normal_coord(py, s);
		d2 = nx * nx + ny * ny;
		c.alpha = ALPHA_OPAQUE;
		if (d2 <= 64'd1 << 32) begin
			nz = root64((64'd1 << 32) - d2);
			dotp = nx * longint'(LIGHT_X) - ny * longint'(LIGHT_Y) + nz * longint'(LIGHT_Z);
			diff = dotp > 0 ? (dotp >>> 16) : 0;
			t = 65536 - nz;
			rim = (t * t) >>> 18;
			f = longint'(AMBIENT_Q16) + ((diff * longint'(DIFFUSE_Q16)) >>> 16);
			c.red = lit_channel(base_r, f, rim);
			c.green = lit_channel(base_g, f, rim);
			c.blue = lit_channel(base_b, f, rim);
		end else begin
			c.red = (((px >> 3) + (py >> 3)) & 1) ? CHECK_DARK : CHECK_LIGHT;
			c.green = c.red;
			c.blue = c.red;
		end
		return c;
	endfunction

	// Output side: random stalls, plus a long hold-off when requested.
	always @(negedge clk) begin
		if (hold_asks != hold_taken) begin
			hold_taken <= hold_asks;
			hold_cycles <= 300;
			rgba_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rgba_ready <= 1'b0;
		end else
			rgba_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 12) == 0);
	end

	always @(posedge clk) begin
		rgba_t want;
		if (rgba_valid && rgba_ready) begin
			pixels_done <= pixels_done + 1;
			if (color_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected color %0d %0d %0d %0d", red, green, blue, alpha);
			end else begin
				want = color_queue.pop_front();
				if (want !== {red, green, blue, alpha}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("color mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
							want.red, want.green, want.blue, want.alpha,
							red, green, blue, alpha);
				end
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_IMAGE_SIZE: side_reg = val[10:0];
			REG_BASE_RED:   base_r = val[7:0];
			REG_BASE_GREEN: base_g = val[7:0];
			default:        base_b = val[7:0];
		endcase
	endtask

	task automatic set_material(int s, int r, int g, int b);
		write_reg(REG_IMAGE_SIZE, s);
		write_reg(REG_BASE_RED, r);
		write_reg(REG_BASE_GREEN, g);
		write_reg(REG_BASE_BLUE, b);
	endtask

	// Valid stays up after a transaction; it drops only for a gap or in drain().
	// The expectation is queued at the accepting edge so the checker sees it in order.
	task automatic send_pixel(int px, int py, bit gaps = 1);
		int gap;
		gap = gaps ? $urandom_range(0, 12) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pos_x <= 10'(px);
		pos_y <= 10'(py);
		do @(posedge clk); while (!pix_ready);
		color_queue.push_back(shade_pixel(10'(px), 10'(py)));
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		wait (pixels_done == pixels_sent);
		repeat (80) @(negedge clk);
	endtask

	task automatic test_corners();
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(0, 1023);
		send_pixel(1023, 0);
		send_pixel(31, 31);
		send_pixel(32, 32);
		send_pixel(10, 32);
		send_pixel(7, 8);
		send_pixel(8, 8);
		send_pixel(10'h2aa, 10'h155);
		send_pixel(10'h155, 10'h2aa);
		drain();
	endtask

	task automatic test_sizes();
		set_material(0, 0, 128, 255);
		send_pixel(0, 0);
		send_pixel(1, 0);
		drain();
		set_material(2047, 255, 0, 17);
		send_pixel(511, 511);
		send_pixel(0, 0);
		send_pixel(1023, 512);
		drain();
		// Size 1: the single pixel sits at the center of the disk.
		set_material(1, 200, 100, 50);
		send_pixel(0, 0);
		drain();
		set_material(50, 9, 250, 128);
		send_pixel(6, 25);
		send_pixel(44, 25);
		send_pixel(25, 44);
		send_pixel(300, 40);
		drain();
	endtask

	task automatic test_random(int count);
		int s;
		for (int k = 0; k < count; k++) begin
			if (k % 200 == 0) begin
				drain();
				s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 96);
				set_material(s, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
			end
			if ($urandom_range(0, 9) == 0)
				send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
			else
				send_pixel($urandom_range(0, side_reg > 0 && side_reg <= 1024 ?
					side_reg - 1 : 1023), $urandom_range(0, side_reg > 0 && side_reg <= 1024 ?
					side_reg - 1 : 1023), k % 3 != 0);
		end
		drain();
	endtask

	task automatic test_backpressure();
		set_material(64, 255, 255, 255);
		hold_asks++;
		for (int k = 0; k < 150; k++)
			send_pixel($urandom_range(0, 63), $urandom_range(0, 63), 0);
		drain();
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_corners();
		test_sizes();
		test_backpressure();
		test_random(1400);
		if (mismatches == 0 && color_queue.size() == 0)
			$display("sphere_preview_pixel_shader_top regression: pass");
		else
			$display("sphere_preview_pixel_shader_top regression: fail");
		$finish;
	end

endmodule
